### rtl/mtf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types and constants for the move-to-front coder.
// ----------------------------------------------------------------------------
package mtf_pkg;

  // width of a symbol id and of a list position
  localparam int unsigned SYM_W = 5;

  // direction register codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef logic [SYM_W-1:0] sym_t;

  // lookup request broadcast to every cell
  typedef struct packed {
    logic restart;
    logic decode;
    sym_t value;
  } cell_req_t;

  // update command broadcast to every cell
  typedef struct packed {
    logic accept;
    logic shift_en;
    sym_t pos;
  } cell_upd_t;

endpackage
`default_nettype wire

### rtl/mtf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtf_in_if
// Input channel of the move-to-front coder: value and restart flag.
// ----------------------------------------------------------------------------
interface mtf_in_if;
  logic                      valid;
  logic                      ready;
  logic [mtf_pkg::SYM_W-1:0] value_in;
  logic                      restart;

  modport source (output valid, output value_in, output restart, input ready);
  modport sink   (input valid, input value_in, input restart, output ready);
endinterface
`default_nettype wire

### rtl/mtf_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtf_out_if
// Output channel of the move-to-front coder: coded value and error flag.
// ----------------------------------------------------------------------------
interface mtf_out_if;
  logic                      valid;
  logic                      ready;
  logic [mtf_pkg::SYM_W-1:0] value_out;
  logic                      error;

  modport source (output valid, output value_out, output error, input ready);
  modport sink   (input valid, input value_out, input error, output ready);
endinterface
`default_nettype wire

### rtl/mtf_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtf_cell
// One list entry: compares against the request and shifts from its neighbor.
// ----------------------------------------------------------------------------
module mtf_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtf_pkg::cell_req_t req_i,
  input  mtf_pkg::cell_upd_t upd_i,
  input  mtf_pkg::sym_t      prev_sym_i,
  output mtf_pkg::sym_t      eff_sym_o,
  output logic               match_o
);
  import mtf_pkg::*;

  localparam sym_t MY_POS = sym_t'(INDEX);

  sym_t sym_q, sym_d;
  logic take_prev;

  // entry as seen by this item, after an optional restart
  assign eff_sym_o = req_i.restart ? MY_POS : sym_q;

  assign match_o = (req_i.decode == DIR_DECODE) ? (req_i.value == MY_POS)
                                                 : (req_i.value == eff_sym_o);

  // entries at or before the hit position move back one place
  assign take_prev = upd_i.shift_en && (MY_POS <= upd_i.pos);

  always_comb begin
    sym_d = sym_q;
    if (upd_i.accept) begin
      sym_d = take_prev ? prev_sym_i : eff_sym_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q <= MY_POS;
    end else begin
      sym_q <= sym_d;
    end
  end

endmodule
`default_nettype wire

### rtl/move_to_front_coder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// move_to_front_coder
// Move-to-front encoder/decoder built from a row of list cells.
// ----------------------------------------------------------------------------
// usage
//   in_i  : valid/ready channel carrying value_in and restart; one transfer
//           is one item
//   out_o : valid/ready channel carrying value_out and error; exactly one
//           transfer per input item, in order
//   cfg_we_i / cfg_wdata_i : direction register, 0 encodes, 1 decodes;
//           write only while no item is in flight
//   result: registered in the output register; it appears in the cycle after the input transfer
//   throughput: one item per cycle while the receiver takes each result; every cell compares and shifts in the
//           same cycle, so the row of cells sets the rate
//   the output register separates the sides: a new item is taken while the
//           held result is being taken in the same cycle
//   when the receiver stalls, the result holds and in_i.ready drops until
//           the output register drains
//   reset: the list returns to identity order (entry i holds i), direction
//           clears to encode, and no result is pending
//   values outside the alphabet return error with value 0 and leave the
//           list alone, except that a restart on that item still applies
// ----------------------------------------------------------------------------
module move_to_front_coder #(
  parameter int unsigned ALPHABET_SIZE = 27
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  mtf_in_if.sink   in_i,
  mtf_out_if.source out_o
);
  import mtf_pkg::*;

  // direction register
  logic dir_q;

  // output register
  logic out_valid_q;
  sym_t value_out_q, value_out_d;
  logic error_q, error_d;

  // cell row
  sym_t                     eff_sym [ALPHABET_SIZE];
  sym_t                     prev_sym [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] match;
  cell_req_t                req;
  cell_upd_t                upd;

  logic accept;
  logic out_of_range;
  sym_t hit_idx;
  sym_t hit_sym;
  sym_t hit_pos;
  sym_t front_sym;

  // a new item enters when the output register is empty or draining
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign out_of_range = {1'b0, in_i.value_in} >= (SYM_W + 1)'(ALPHABET_SIZE);

  assign req.restart = in_i.restart;
  assign req.decode  = dir_q;
  assign req.value   = in_i.value_in;

  // gather the single matching cell: its position and its symbol
  always_comb begin
    hit_idx = '0;
    hit_sym = '0;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | sym_t'(i);
        hit_sym = hit_sym | eff_sym[i];
      end
    end
  end

  // position to promote and the symbol that lands at the front
  assign hit_pos   = (dir_q == DIR_DECODE) ? in_i.value_in : hit_idx;
  assign front_sym = (dir_q == DIR_DECODE) ? hit_sym : in_i.value_in;

  assign upd.accept   = accept;
  assign upd.shift_en = !out_of_range;
  assign upd.pos      = hit_pos;

  // each cell takes its left neighbor; the first cell takes the promoted symbol
  assign prev_sym[0] = front_sym;
  for (genvar g = 1; g < ALPHABET_SIZE; g++) begin : g_link
    assign prev_sym[g] = eff_sym[g-1];
  end

  for (genvar g = 0; g < ALPHABET_SIZE; g++) begin : g_cell
    mtf_cell #(
      .INDEX (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .req_i      (req),
      .upd_i      (upd),
      .prev_sym_i (prev_sym[g]),
      .eff_sym_o  (eff_sym[g]),
      .match_o    (match[g])
    );
  end

  // encode returns the position, decode returns the symbol
  always_comb begin
    if (out_of_range) begin
      value_out_d = '0;
      error_d     = 1'b1;
    end else begin
      value_out_d = (dir_q == DIR_DECODE) ? hit_sym : hit_idx;
      error_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DIR_ENCODE;
    end else if (cfg_we_i) begin
      dir_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_out_q <= value_out_d;
      error_q     <= error_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.value_out = value_out_q;
  assign out_o.error     = error_q;

`ifndef NO_ASSERTIONS
  // the list stays a permutation, so an in-range item hits exactly one cell
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !out_of_range) |-> $onehot(match))
    else $error("in-range item did not hit exactly one cell");

  // every transfer in produces a pending result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted item left no result");

  // out-of-range values report an error with a zero value
  a_range_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && out_of_range) |=> (error_q && (value_out_q == '0)))
    else $error("out-of-range item not flagged");

  // in-range results are never flagged and stay inside the alphabet
  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !out_of_range) |=>
      (!error_q && ({1'b0, value_out_q} < (SYM_W + 1)'(ALPHABET_SIZE))))
    else $error("in-range item gave a bad result");
`endif

endmodule
`default_nettype wire

### verif/move_to_front_coder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_coder_test
// Self-checking bench for the move-to-front coder. A queue of symbols feeds
// a clocked driver on the input channel. At every input transfer a local copy
// of the symbol list works out the coded value and the error flag that must
// come back. A clocked monitor on the output channel checks each result
// against the oldest outstanding prediction. The run walks both directions
// under several idle and stall mixes.
// ----------------------------------------------------------------------------
module move_to_front_coder_test;
  import mtf_pkg::*;

  localparam int unsigned ALPHABET_SIZE  = 27;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          PHASE_ITEMS    = 75;
  localparam int          DRAIN_CYCLES   = 3;

  // one input transfer and one output transfer
  typedef struct packed {
    sym_t value;
    logic restart;
  } mtf_item_t;

  typedef struct packed {
    sym_t value;
    logic error;
  } mtf_result_t;

  logic clk_i;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  mtf_in_if  in_ch ();
  mtf_out_if out_ch ();

  move_to_front_coder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // symbols waiting for the driver, codes waiting for the monitor
  mtf_item_t   symbols_to_send[$];
  mtf_result_t pending_codes[$];

  // local copy of the coder state
  sym_t symbol_order[ALPHABET_SIZE];
  logic dir_model;

  // idle mix of the current phase, in percent
  int send_idle_pct;
  int recv_stall_pct;

  // bookkeeping
  int items_queued;
  int items_taken;
  int results_checked;
  int mismatch_count;
  int encode_items;
  int decode_items;
  int restart_items;
  int range_errors;
  int stall_cycles;

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // list back to identity order
  function automatic void order_identity();
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      symbol_order[i] = sym_t'(i);
    end
  endfunction

  // code one symbol or position and move its entry to the front
  function automatic mtf_result_t code_symbol(mtf_item_t it);
    mtf_result_t res;
    int          pos;
    sym_t        sym;
    res = '0;
    pos = 0;
    if (it.restart) begin
      order_identity();
    end
    // out of range: error with zero, list untouched apart from a restart
    if (it.value >= ALPHABET_SIZE) begin
      res.error = 1'b1;
      return res;
    end
    if (dir_model == DIR_ENCODE) begin
      for (int i = ALPHABET_SIZE - 1; i >= 0; i--) begin
        if (symbol_order[i] == it.value) begin
          pos = i;
        end
      end
      res.value = sym_t'(pos);
    end else begin
      pos       = it.value;
      res.value = symbol_order[pos];
    end
    // entries ahead of the hit shift back one place
    sym = symbol_order[pos];
    for (int i = pos; i > 0; i--) begin
      symbol_order[i] = symbol_order[i-1];
    end
    symbol_order[0] = sym;
    return res;
  endfunction

  // driver: predicts on each input transfer, then presents the next symbol
  always @(posedge clk_i) begin
    mtf_item_t taken;
    mtf_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken.value   = in_ch.value_in;
        taken.restart = in_ch.restart;
        pending_codes.insert(pending_codes.size(), code_symbol(taken));
        items_taken++;
        if (dir_model == DIR_ENCODE) encode_items++;
        else decode_items++;
        if (taken.restart) restart_items++;
        if (taken.value >= ALPHABET_SIZE) range_errors++;
      end
      // a stalled transfer keeps its payload; otherwise maybe idle
      if (in_ch.valid && !in_ch.ready) begin
        in_ch.valid <= 1'b1;
      end else if (symbols_to_send.size() != 0 &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = symbols_to_send.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.value_in <= nxt.value;
        in_ch.restart  <= nxt.restart;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: random back-pressure, field-by-field check of each transfer
  always @(posedge clk_i) begin
    mtf_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (pending_codes.size() == 0) begin
          $error("result transfer with nothing expected: value_out %0d error %0b",
                 out_ch.value_out, out_ch.error);
          mismatch_count++;
        end else begin
          want = pending_codes.pop_front();
          if (out_ch.value_out !== want.value) begin
            $error("value_out: expected %0d, actual %0d", want.value, out_ch.value_out);
            mismatch_count++;
          end
          if (out_ch.error !== want.error) begin
            $error("error: expected %0b, actual %0b", want.error, out_ch.error);
            mismatch_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // cycles without any transfer on either side
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("move_to_front_coder_test: done, errors");
    $finish;
  end

  task automatic queue_item(sym_t v, logic r);
    mtf_item_t it;
    it.value   = v;
    it.restart = r;
    symbols_to_send.insert(symbols_to_send.size(), it);
    items_queued++;
  endtask

  // mostly in-range values, a cluster of small ones for repeats and short
  // positions, some out of range, an occasional restart
  task automatic queue_random(int count);
    int   pick;
    sym_t v;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) v = sym_t'($urandom_range(ALPHABET_SIZE, 31));
      else if (pick < 45) v = sym_t'($urandom_range(0, 3));
      else v = sym_t'($urandom_range(0, ALPHABET_SIZE - 1));
      queue_item(v, $urandom_range(0, 99) < 4);
    end
  endtask

  // hold off until every queued symbol has its result back
  task automatic drain();
    while (items_taken != items_queued || pending_codes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // direction write, only with nothing in flight
  task automatic set_direction(logic dir);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= dir;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    dir_model = dir;
  endtask

  initial begin
    int send_tab[4];
    int recv_tab[4];
    send_tab = '{0, 50, 0, 18};
    recv_tab = '{0, 0, 50, 18};

    // every input known from time zero
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = DIR_ENCODE;
    in_ch.valid    = 1'b0;
    in_ch.value_in = '0;
    in_ch.restart  = 1'b0;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    stall_cycles   = 0;
    order_identity();
    dir_model = DIR_ENCODE;

    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;

    // directed encode: front hit, far end, repeat, out of range at both
    // ends, restart with a legal value, restart with an illegal one
    set_direction(DIR_ENCODE);
    queue_item(5'd0, 1'b0);
    queue_item(5'd26, 1'b0);
    queue_item(5'd26, 1'b0);
    queue_item(5'd1, 1'b0);
    queue_item(5'd27, 1'b0);
    queue_item(5'd31, 1'b0);
    queue_item(5'd13, 1'b0);
    queue_item(5'd5, 1'b1);
    queue_item(5'd26, 1'b0);
    queue_item(5'd31, 1'b1);
    queue_item(5'd26, 1'b0);
    queue_item(5'd30, 1'b0);
    drain();

    // directed decode: same corners seen as positions
    set_direction(DIR_DECODE);
    queue_item(5'd0, 1'b0);
    queue_item(5'd26, 1'b0);
    queue_item(5'd26, 1'b0);
    queue_item(5'd27, 1'b0);
    queue_item(5'd31, 1'b0);
    queue_item(5'd13, 1'b1);
    queue_item(5'd28, 1'b1);
    queue_item(5'd1, 1'b0);
    queue_item(5'd25, 1'b0);
    queue_item(5'd0, 1'b0);
    drain();

    // random phases: encode then decode, each through all idle mixes;
    // mid-phase the sender waits for every result before going on
    for (int p = 0; p < 8; p++) begin
      set_direction(p < 4 ? DIR_ENCODE : DIR_DECODE);
      send_idle_pct  = send_tab[p % 4];
      recv_stall_pct = recv_tab[p % 4];
      queue_random(PHASE_ITEMS / 2);
      drain();
      queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      drain();
    end

    $display("move_to_front_coder_test: %0d items (%0d encode, %0d decode), %0d restarts,",
             items_taken, encode_items, decode_items, restart_items);
    $display("  %0d out of range, %0d results checked under four idle/stall mixes",
             range_errors, results_checked);
    if (mismatch_count == 0) begin
      $display("move_to_front_coder_test: done, clean");
    end else begin
      $display("move_to_front_coder_test: done, errors");
    end
    $finish;
  end

endmodule
